// ===== hw/rtl/dfr_pkg.sv =====
// Shared constants, field codes and the CRC-16 byte update for the packet deframer.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned CountW = 9;

  localparam logic [CrcW-1:0]   CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]   CrcPoly = 16'h1021;
  localparam logic [CountW-1:0] CrcLen  = 9'd2;

  // Field codes carried on the result channel
  localparam logic [KindW-1:0] KIND_DEVICE  = 3'd0;
  localparam logic [KindW-1:0] KIND_OPCODE  = 3'd1;
  localparam logic [KindW-1:0] KIND_LENGTH  = 3'd2;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd3;
  localparam logic [KindW-1:0] KIND_CRC     = 3'd4;

  // CRC-16/CCITT-FALSE, MSB first, one byte unrolled over eight bit steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dfr_if.sv =====
// Valid/ready channel interfaces for received bytes and tagged result items.
`timescale 1ns / 1ps

interface dfr_in_if;
  import dfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  import dfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [KindW-1:0] field_kind;
  logic             packet_end;
  logic             crc_ok;

  modport source (output valid, output data_byte, output field_kind, output packet_end,
                  output crc_ok, input ready);
  modport sink   (input valid, input data_byte, input field_kind, input packet_end,
                  input crc_ok, output ready);
endinterface

// ===== hw/rtl/packet_deframer_with_crc16_check.sv =====
// Top level: length-prefixed packet deframer with running CRC-16 check.
`timescale 1ns / 1ps

// Usage
//   rx_i  : one received serial byte per item (valid/ready).
//   res_o : one result item per received byte: the byte itself, its field
//           kind (device, opcode, length, payload, crc), packet_end on the
//           last byte of a packet and crc_ok alongside it.
//   Packets are device, opcode, length L, L payload bytes, two CRC bytes
//   (MSB first). The CRC covers the whole packet; a zero residue is good.
// Pipeline and throughput
//   An accepted byte lands in an input register. When the result register
//   can take it, it is classified, folded into the CRC and written to the
//   result register, which offers it on res_o. One byte per cycle is
//   sustained while res_o.ready stays high; the limit is the 8-bit unrolled
//   CRC update between the input register and the result register.
// Reset
//   rst_ni clears both pipeline valids and returns the parser to waiting for
//   a device byte with the CRC at 0xFFFF.
// Stall
//   While res_o.ready is low the result register holds and the input
//   register fills; rx_i.ready drops only once both are occupied.
module packet_deframer_with_crc16_check (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfr_in_if.sink    rx_i,
  dfr_out_if.source res_o
);
  import dfr_pkg::*;

  typedef enum logic [1:0] {
    PH_DEVICE,
    PH_OPCODE,
    PH_LENGTH,
    PH_BODY
  } phase_e;

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Parser state
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [CrcW-1:0]   crc_q, crc_d;

  // Result register
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [KindW-1:0] out_kind_q, kind_d;
  logic             out_end_q, end_d;
  logic             out_ok_q, ok_d;

  logic            advance;
  logic            rx_accept;
  logic [CrcW-1:0] crc_upd;

  // Move the held byte into the result register when that slot frees up
  assign advance   = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign rx_accept = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Classify the held byte and update the counter and CRC
  always_comb begin
    crc_upd  = crc_byte(crc_q, in_byte_q);
    crc_d    = crc_upd;
    phase_d  = phase_q;
    remain_d = remain_q;
    kind_d   = KIND_DEVICE;
    end_d    = 1'b0;
    ok_d     = 1'b0;
    case (phase_q)
      PH_DEVICE: begin
        kind_d   = KIND_DEVICE;
        phase_d  = PH_OPCODE;
        remain_d = CountW'(1);
      end
      PH_OPCODE: begin
        kind_d   = KIND_OPCODE;
        phase_d  = PH_LENGTH;
        remain_d = CountW'(1);
      end
      PH_LENGTH: begin
        kind_d   = KIND_LENGTH;
        phase_d  = PH_BODY;
        // Payload length plus the two trailing CRC bytes
        remain_d = {1'b0, in_byte_q} + CrcLen;
      end
      PH_BODY: begin
        // The last two bytes of the body are the CRC
        kind_d = (remain_q > CrcLen) ? KIND_PAYLOAD : KIND_CRC;
        if (remain_q <= CountW'(1)) begin
          end_d    = 1'b1;
          ok_d     = (crc_upd == '0);
          phase_d  = PH_DEVICE;
          remain_d = CountW'(1);
          crc_d    = CrcInit;
        end else begin
          remain_d = remain_q - CountW'(1);
        end
      end
      default: begin
        phase_d = PH_DEVICE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DEVICE;
      remain_q    <= CountW'(1);
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        remain_q    <= remain_d;
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_kind_q <= kind_d;
      out_end_q  <= end_d;
      out_ok_q   <= ok_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.data_byte  = out_byte_q;
  assign res_o.field_kind = out_kind_q;
  assign res_o.packet_end = out_end_q;
  assign res_o.crc_ok     = out_ok_q;

endmodule
